// ===== rtl/ec_prime_field_point_unit_defines.svh =====
// ----------------------------------------------------------------------------
// ec_prime_field_point_unit assertion macros
// Shared property shapes for the point unit; clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef EC_PRIME_FIELD_POINT_UNIT_DEFINES_SVH
`define EC_PRIME_FIELD_POINT_UNIT_DEFINES_SVH

// same-cycle implication
`define ECPU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ECPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ecpu_pkg.sv =====
// ----------------------------------------------------------------------------
// ecpu_pkg
// Types, codes and the microprogram of the prime-field point unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ecpu_pkg;

  localparam int FIELD_W   = 31;
  localparam int SCALAR_W  = 63;
  localparam int CFG_IDX_W = 2;
  localparam int PC_W      = 7;
  localparam int RF_DEPTH  = 16;

  // function codes
  localparam logic [1:0] FN_SCALAR_MUL = 2'd0;
  localparam logic [1:0] FN_POINT_ADD  = 2'd1;
  localparam logic [1:0] FN_NEGATE     = 2'd2;
  localparam logic [1:0] FN_CHECK      = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B     = 2'd2;

  typedef struct packed {
    logic [1:0]          func;
    logic [SCALAR_W-1:0] scalar;
    logic [FIELD_W-1:0]  first_x;
    logic [FIELD_W-1:0]  first_y;
    logic                first_at_infinity;
    logic [FIELD_W-1:0]  second_x;
    logic [FIELD_W-1:0]  second_y;
    logic                second_at_infinity;
  } ecpu_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] result_x;
    logic [FIELD_W-1:0] result_y;
    logic               result_at_infinity;
    logic               on_curve;
  } ecpu_out_t;

  // register file addresses
  typedef logic [3:0] rf_addr_t;
  localparam rf_addr_t R_X1  = 4'd0;
  localparam rf_addr_t R_Y1  = 4'd1;
  localparam rf_addr_t R_X2  = 4'd2;
  localparam rf_addr_t R_Y2  = 4'd3;
  localparam rf_addr_t R_X3  = 4'd4;
  localparam rf_addr_t R_Y3  = 4'd5;
  localparam rf_addr_t R_A   = 4'd6;
  localparam rf_addr_t R_B   = 4'd7;
  localparam rf_addr_t R_M   = 4'd8;
  localparam rf_addr_t R_T   = 4'd9;
  localparam rf_addr_t R_U   = 4'd10;
  localparam rf_addr_t R_D   = 4'd11;
  localparam rf_addr_t R_INV = 4'd12;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_NEG, OP_MOV, OP_ONE, OP_MUL, OP_RED,
    OP_OUTX, OP_OUTY, OP_ELOAD, OP_ESHIFT, OP_KSHIFT
  } dp_op_t;

  typedef struct packed {
    logic     valid;
    dp_op_t   op;
    rf_addr_t dst;
    rf_addr_t sa;
    rf_addr_t sb;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic zero;
    logic e_zero;
    logic e_lsb;
    logic k_zero;
    logic k_lsb;
  } dp_stat_t;

  typedef struct packed {
    logic finish;
    logic inf;
    logic is_check;
    logic chk;
  } ctrl_res_t;

  typedef enum logic [2:0] {MK_OP, MK_JMP, MK_CALL, MK_RET, MK_FLAG, MK_FIN} ukind_t;

  typedef enum logic [3:0] {
    C_ALWAYS, C_INF1, C_INF2, C_XEQ_SUMZ, C_XEQ_YEQ, C_EZERO, C_ELSB0,
    C_KZERO, C_KLSB0, C_FN_MUL, C_FN_ADD, C_FN_NEG
  } ucond_t;

  typedef enum logic [3:0] {
    FL_XEQ, FL_SUMZ, FL_YEQ, FL_CHK, FL_CHK_SET, FL_INF1_SET, FL_INF1_CLR,
    FL_INF1_FROM2, FL_INF2_FROM1
  } uflag_t;

  typedef struct packed {
    ukind_t          kind;
    dp_op_t          op;
    rf_addr_t        dst;
    rf_addr_t        sa;
    rf_addr_t        sb;
    ucond_t          cond;
    uflag_t          flag;
    logic            side;
    logic [PC_W-1:0] target;
  } uinstr_t;

  // microprogram labels
  localparam logic [PC_W-1:0] L_CHKINF = 7'd19;
  localparam logic [PC_W-1:0] L_NEG    = 7'd21;
  localparam logic [PC_W-1:0] L_ADD    = 7'd23;
  localparam logic [PC_W-1:0] L_SM     = 7'd25;
  localparam logic [PC_W-1:0] L_SMLOOP = 7'd29;
  localparam logic [PC_W-1:0] L_SMDBL  = 7'd32;
  localparam logic [PC_W-1:0] L_SMEND  = 7'd35;
  localparam logic [PC_W-1:0] L_PADD   = 7'd36;
  localparam logic [PC_W-1:0] L_DBL    = 7'd49;
  localparam logic [PC_W-1:0] L_INV    = 7'd54;
  localparam logic [PC_W-1:0] L_INVLP  = 7'd56;
  localparam logic [PC_W-1:0] L_INVSQ  = 7'd59;
  localparam logic [PC_W-1:0] L_SLOPE  = 7'd62;
  localparam logic [PC_W-1:0] L_P1INF  = 7'd73;
  localparam logic [PC_W-1:0] L_PINF   = 7'd77;
  localparam logic [PC_W-1:0] L_RET    = 7'd78;
  localparam logic [PC_W-1:0] L_TAIL   = 7'd79;

  function automatic uinstr_t u_op(dp_op_t op, rf_addr_t dst, rf_addr_t sa, rf_addr_t sb);
    uinstr_t u;
    u      = '0;
    u.kind = MK_OP;
    u.op   = op;
    u.dst  = dst;
    u.sa   = sa;
    u.sb   = sb;
    return u;
  endfunction

  function automatic uinstr_t u_jmp(ucond_t cond, logic [PC_W-1:0] target);
    uinstr_t u;
    u        = '0;
    u.kind   = MK_JMP;
    u.cond   = cond;
    u.target = target;
    return u;
  endfunction

  function automatic uinstr_t u_call(logic [PC_W-1:0] target, logic side);
    uinstr_t u;
    u        = '0;
    u.kind   = MK_CALL;
    u.target = target;
    u.side   = side;
    return u;
  endfunction

  function automatic uinstr_t u_flag(uflag_t flag);
    uinstr_t u;
    u      = '0;
    u.kind = MK_FLAG;
    u.flag = flag;
    return u;
  endfunction

  function automatic uinstr_t u_kind(ukind_t kind);
    uinstr_t u;
    u      = '0;
    u.kind = kind;
    return u;
  endfunction

  // microprogram ROM
  function automatic uinstr_t ucode(logic [PC_W-1:0] pc);
    uinstr_t u;
    case (pc)
      // reduce operands and curve constants
      7'd0:  u = u_op(OP_RED, R_X1, R_X1, R_X1);
      7'd1:  u = u_op(OP_RED, R_Y1, R_Y1, R_Y1);
      7'd2:  u = u_op(OP_RED, R_X2, R_X2, R_X2);
      7'd3:  u = u_op(OP_RED, R_Y2, R_Y2, R_Y2);
      7'd4:  u = u_op(OP_RED, R_A, R_A, R_A);
      7'd5:  u = u_op(OP_RED, R_B, R_B, R_B);
      7'd6:  u = u_jmp(C_FN_MUL, L_SM);
      7'd7:  u = u_jmp(C_FN_ADD, L_ADD);
      7'd8:  u = u_jmp(C_FN_NEG, L_NEG);
      // on-curve check
      7'd9:  u = u_jmp(C_INF1, L_CHKINF);
      7'd10: u = u_op(OP_MUL, R_T, R_X1, R_X1);
      7'd11: u = u_op(OP_MUL, R_T, R_T, R_X1);
      7'd12: u = u_op(OP_MUL, R_U, R_A, R_X1);
      7'd13: u = u_op(OP_ADD, R_T, R_T, R_U);
      7'd14: u = u_op(OP_ADD, R_T, R_T, R_B);
      7'd15: u = u_op(OP_MUL, R_U, R_Y1, R_Y1);
      7'd16: u = u_op(OP_SUB, R_U, R_U, R_T);
      7'd17: u = u_flag(FL_CHK);
      7'd18: u = u_jmp(C_ALWAYS, L_TAIL);
      7'd19: u = u_flag(FL_CHK_SET);
      7'd20: u = u_jmp(C_ALWAYS, L_TAIL);
      // negate
      7'd21: u = u_op(OP_NEG, R_Y1, R_Y1, R_Y1);
      7'd22: u = u_jmp(C_ALWAYS, L_TAIL);
      // point add
      7'd23: u = u_call(L_PADD, 1'b0);
      7'd24: u = u_jmp(C_ALWAYS, L_TAIL);
      // scalar multiply: slot 1 accumulates, slot 2 holds the base
      7'd25: u = u_op(OP_MOV, R_X2, R_X1, R_X1);
      7'd26: u = u_op(OP_MOV, R_Y2, R_Y1, R_Y1);
      7'd27: u = u_flag(FL_INF2_FROM1);
      7'd28: u = u_flag(FL_INF1_SET);
      7'd29: u = u_jmp(C_KZERO, L_SMEND);
      7'd30: u = u_jmp(C_KLSB0, L_SMDBL);
      7'd31: u = u_call(L_PADD, 1'b0);
      7'd32: u = u_call(L_PADD, 1'b1);
      7'd33: u = u_op(OP_KSHIFT, R_X1, R_X1, R_X1);
      7'd34: u = u_jmp(C_ALWAYS, L_SMLOOP);
      7'd35: u = u_jmp(C_ALWAYS, L_TAIL);
      // add subroutine: slot 1 <= slot 1 + slot 2
      7'd36: u = u_jmp(C_INF1, L_P1INF);
      7'd37: u = u_jmp(C_INF2, L_RET);
      7'd38: u = u_op(OP_SUB, R_U, R_X1, R_X2);
      7'd39: u = u_flag(FL_XEQ);
      7'd40: u = u_op(OP_ADD, R_U, R_Y1, R_Y2);
      7'd41: u = u_flag(FL_SUMZ);
      7'd42: u = u_op(OP_SUB, R_U, R_Y1, R_Y2);
      7'd43: u = u_flag(FL_YEQ);
      7'd44: u = u_jmp(C_XEQ_SUMZ, L_PINF);
      7'd45: u = u_jmp(C_XEQ_YEQ, L_DBL);
      7'd46: u = u_op(OP_SUB, R_T, R_Y2, R_Y1);
      7'd47: u = u_op(OP_SUB, R_D, R_X2, R_X1);
      7'd48: u = u_jmp(C_ALWAYS, L_INV);
      7'd49: u = u_op(OP_MUL, R_M, R_X1, R_X1);
      7'd50: u = u_op(OP_ADD, R_T, R_M, R_M);
      7'd51: u = u_op(OP_ADD, R_T, R_T, R_M);
      7'd52: u = u_op(OP_ADD, R_T, R_T, R_A);
      7'd53: u = u_op(OP_ADD, R_D, R_Y1, R_Y1);
      // Fermat inverse of D
      7'd54: u = u_op(OP_ONE, R_INV, R_INV, R_INV);
      7'd55: u = u_op(OP_ELOAD, R_INV, R_INV, R_INV);
      7'd56: u = u_jmp(C_EZERO, L_SLOPE);
      7'd57: u = u_jmp(C_ELSB0, L_INVSQ);
      7'd58: u = u_op(OP_MUL, R_INV, R_INV, R_D);
      7'd59: u = u_op(OP_MUL, R_D, R_D, R_D);
      7'd60: u = u_op(OP_ESHIFT, R_D, R_D, R_D);
      7'd61: u = u_jmp(C_ALWAYS, L_INVLP);
      7'd62: u = u_op(OP_MUL, R_M, R_T, R_INV);
      7'd63: u = u_op(OP_MUL, R_U, R_M, R_M);
      7'd64: u = u_op(OP_SUB, R_U, R_U, R_X1);
      7'd65: u = u_op(OP_SUB, R_X3, R_U, R_X2);
      7'd66: u = u_op(OP_SUB, R_T, R_X1, R_X3);
      7'd67: u = u_op(OP_MUL, R_T, R_M, R_T);
      7'd68: u = u_op(OP_SUB, R_Y3, R_T, R_Y1);
      7'd69: u = u_op(OP_MOV, R_X1, R_X3, R_X3);
      7'd70: u = u_op(OP_MOV, R_Y1, R_Y3, R_Y3);
      7'd71: u = u_flag(FL_INF1_CLR);
      7'd72: u = u_kind(MK_RET);
      7'd73: u = u_op(OP_MOV, R_X1, R_X2, R_X2);
      7'd74: u = u_op(OP_MOV, R_Y1, R_Y2, R_Y2);
      7'd75: u = u_flag(FL_INF1_FROM2);
      7'd76: u = u_kind(MK_RET);
      7'd77: u = u_flag(FL_INF1_SET);
      7'd78: u = u_kind(MK_RET);
      // result readout
      7'd79: u = u_op(OP_OUTX, R_X1, R_X1, R_X1);
      7'd80: u = u_op(OP_OUTY, R_Y1, R_Y1, R_Y1);
      default: u = u_kind(MK_FIN);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ecpu_dp.sv =====
// ----------------------------------------------------------------------------
// ecpu_dp
// Field datapath: register file, add/sub unit, bit-serial modular multiplier,
// exponent and scalar shifters, configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ecpu_dp import ecpu_pkg::*; #(
  parameter int FIELD_BITS  = 31,
  parameter int SCALAR_BITS = 63
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire ecpu_in_t             operands,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [FIELD_W-1:0]   cfg_data,
  input  wire dp_cmd_t              cmd,
  output dp_stat_t                  stat,
  output logic [FIELD_BITS-1:0]     out_x,
  output logic [FIELD_BITS-1:0]     out_y
);

  localparam int W     = FIELD_BITS;
  localparam int CNT_W = $clog2(W);

  typedef enum logic [2:0] {
    DS_IDLE = 3'b001,
    DS_EXEC = 3'b010,
    DS_MUL  = 3'b100
  } dstate_t;

  dstate_t state;

  logic [W-1:0]           p, ca, cb;
  logic [W-1:0]           rx1, ry1, rx2, ry2;
  logic [SCALAR_BITS-1:0] k;
  logic [W-1:0]           e;
  logic [W-1:0]           rf [RF_DEPTH];
  logic [W-1:0]           ra, rb;
  dp_op_t                 op_q;
  rf_addr_t               dst_q, sb_q;
  logic [W-1:0]           mu, mv, mr;
  logic [CNT_W-1:0]       cnt;
  logic                   done, zero;

  logic                   p_small;
  logic [W-1:0]           raw_sel, alu_res, mul_step, wval;
  logic                   we;

  function automatic logic [W-1:0] madd(logic [W-1:0] u, logic [W-1:0] v, logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, u} + {1'b0, v};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] msub(logic [W-1:0] u, logic [W-1:0] v, logic [W-1:0] m);
    logic [W:0] s;
    if (u >= v) s = {1'b0, u} - {1'b0, v};
    else        s = {1'b0, u} + {1'b0, m} - {1'b0, v};
    return s[W-1:0];
  endfunction

  assign p_small = (p < W'(2));

  always_comb begin
    case (sb_q)
      R_X1:    raw_sel = rx1;
      R_Y1:    raw_sel = ry1;
      R_X2:    raw_sel = rx2;
      R_Y2:    raw_sel = ry2;
      R_A:     raw_sel = ca;
      R_B:     raw_sel = cb;
      default: raw_sel = '0;
    endcase
  end

  always_comb begin
    case (op_q)
      OP_ADD:  alu_res = madd(ra, rb, p);
      OP_SUB:  alu_res = msub(ra, rb, p);
      OP_NEG:  alu_res = msub('0, ra, p);
      OP_MOV:  alu_res = ra;
      OP_ONE:  alu_res = W'(1);
      default: alu_res = '0;
    endcase
  end

  // one Horner step: r = 2r + bit*u mod p
  assign mul_step = madd(madd(mr, mr, p), mv[W-1] ? mu : '0, p);

  always_comb begin
    we   = 1'b0;
    wval = alu_res;
    if (state == DS_EXEC) begin
      we = (op_q == OP_ADD) || (op_q == OP_SUB) || (op_q == OP_NEG) ||
           (op_q == OP_MOV) || (op_q == OP_ONE);
    end else if (state == DS_MUL && cnt == '0) begin
      we   = 1'b1;
      wval = mul_step;
    end
    if (p_small) wval = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.valid) begin
      ra <= rf[cmd.sa];
      rb <= rf[cmd.sb];
    end
    if (we) rf[dst_q] <= wval;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DS_IDLE;
      done  <= 1'b0;
      zero  <= 1'b0;
      p     <= W'(11);
      ca    <= W'(1);
      cb    <= W'(6);
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_PRIME: p  <= W'(cfg_data);
          CFG_A:     ca <= W'(cfg_data);
          CFG_B:     cb <= W'(cfg_data);
          default:   ;
        endcase
      end
      case (state)
        DS_IDLE: begin
          if (cmd.valid) state <= DS_EXEC;
        end
        DS_EXEC: begin
          if (op_q == OP_MUL || op_q == OP_RED) begin
            state <= DS_MUL;
          end else begin
            state <= DS_IDLE;
            done  <= 1'b1;
            if (we) zero <= (wval == '0);
          end
        end
        DS_MUL: begin
          if (cnt == '0) begin
            state <= DS_IDLE;
            done  <= 1'b1;
            zero  <= (wval == '0);
          end
        end
        default: state <= DS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rx1 <= W'(operands.first_x);
      ry1 <= W'(operands.first_y);
      rx2 <= W'(operands.second_x);
      ry2 <= W'(operands.second_y);
      k   <= SCALAR_BITS'(operands.scalar);
    end
    if (cmd.valid) begin
      op_q  <= cmd.op;
      dst_q <= cmd.dst;
      sb_q  <= cmd.sb;
    end
    if (state == DS_EXEC) begin
      case (op_q)
        OP_MUL: begin
          mu  <= ra;
          mv  <= rb;
          mr  <= '0;
          cnt <= CNT_W'(W - 1);
        end
        OP_RED: begin
          mu  <= W'(1);
          mv  <= raw_sel;
          mr  <= '0;
          cnt <= CNT_W'(W - 1);
        end
        OP_OUTX:   out_x <= ra;
        OP_OUTY:   out_y <= ra;
        OP_ELOAD:  e <= p_small ? '0 : p - W'(2);
        OP_ESHIFT: e <= e >> 1;
        OP_KSHIFT: k <= k >> 1;
        default:   ;
      endcase
    end else if (state == DS_MUL) begin
      mr  <= mul_step;
      mv  <= mv << 1;
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign stat.done   = done;
  assign stat.zero   = zero;
  assign stat.e_zero = (e == '0);
  assign stat.e_lsb  = e[0];
  assign stat.k_zero = (k == '0);
  assign stat.k_lsb  = k[0];

endmodule

`default_nettype wire

// ===== rtl/ecpu_ctrl.sv =====
// ----------------------------------------------------------------------------
// ecpu_ctrl
// Microsequencer: walks the microprogram, issues datapath commands, keeps the
// infinity and comparison flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ecpu_ctrl import ecpu_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     accept,
  input  wire logic [1:0] func,
  input  wire logic     first_inf,
  input  wire logic     second_inf,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd,
  output ctrl_res_t     res,
  output logic          busy
);

  typedef enum logic [2:0] {
    CS_IDLE  = 3'b001,
    CS_FETCH = 3'b010,
    CS_WAIT  = 3'b100
  } cstate_t;

  cstate_t         state;
  logic [PC_W-1:0] pc, ret;
  logic [1:0]      func_q;
  logic            inf1, inf2, xeq, sumz, yeq, chk, side;
  uinstr_t         ui;
  logic            inf1_eff, cond_hit;

  function automatic rf_addr_t remap(rf_addr_t a, logic s);
    rf_addr_t r;
    r = a;
    if (s && a == R_X1) r = R_X2;
    if (s && a == R_Y1) r = R_Y2;
    return r;
  endfunction

  assign ui       = ucode(pc);
  assign inf1_eff = side ? inf2 : inf1;

  always_comb begin
    case (ui.cond)
      C_ALWAYS:   cond_hit = 1'b1;
      C_INF1:     cond_hit = inf1_eff;
      C_INF2:     cond_hit = inf2;
      C_XEQ_SUMZ: cond_hit = xeq && sumz;
      C_XEQ_YEQ:  cond_hit = xeq && yeq;
      C_EZERO:    cond_hit = stat.e_zero;
      C_ELSB0:    cond_hit = !stat.e_lsb;
      C_KZERO:    cond_hit = stat.k_zero;
      C_KLSB0:    cond_hit = !stat.k_lsb;
      C_FN_MUL:   cond_hit = (func_q == FN_SCALAR_MUL);
      C_FN_ADD:   cond_hit = (func_q == FN_POINT_ADD);
      C_FN_NEG:   cond_hit = (func_q == FN_NEGATE);
      default:    cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    cmd.valid = (state == CS_FETCH) && (ui.kind == MK_OP);
    cmd.op    = ui.op;
    cmd.dst   = remap(ui.dst, side);
    cmd.sa    = remap(ui.sa, side);
    cmd.sb    = remap(ui.sb, side);
  end

  assign res.finish   = (state == CS_FETCH) && (ui.kind == MK_FIN);
  assign res.inf      = inf1;
  assign res.is_check = (func_q == FN_CHECK);
  assign res.chk      = chk;
  assign busy         = (state != CS_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
      pc    <= '0;
      side  <= 1'b0;
    end else begin
      case (state)
        CS_IDLE: begin
          if (accept) begin
            state <= CS_FETCH;
            pc    <= '0;
            side  <= 1'b0;
          end
        end
        CS_FETCH: begin
          case (ui.kind)
            MK_OP: begin
              state <= CS_WAIT;
              pc    <= pc + PC_W'(1);
            end
            MK_JMP:  pc <= cond_hit ? ui.target : pc + PC_W'(1);
            MK_CALL: begin
              pc   <= ui.target;
              side <= ui.side;
            end
            MK_RET: begin
              pc   <= ret;
              side <= 1'b0;
            end
            MK_FLAG: pc <= pc + PC_W'(1);
            MK_FIN:  state <= CS_IDLE;
            default: state <= CS_IDLE;
          endcase
        end
        CS_WAIT: begin
          if (stat.done) state <= CS_FETCH;
        end
        default: state <= CS_IDLE;
      endcase
    end
  end

  // flags and return address
  always_ff @(posedge clk) begin
    if (state == CS_IDLE && accept) begin
      func_q <= func;
      inf1   <= first_inf;
      inf2   <= second_inf;
      chk    <= 1'b0;
    end else if (state == CS_FETCH) begin
      if (ui.kind == MK_CALL) ret <= pc + PC_W'(1);
      if (ui.kind == MK_FLAG) begin
        case (ui.flag)
          FL_XEQ:     xeq <= stat.zero;
          FL_SUMZ:    sumz <= stat.zero;
          FL_YEQ:     yeq <= stat.zero;
          FL_CHK:     chk <= stat.zero;
          FL_CHK_SET: chk <= 1'b1;
          FL_INF1_SET: begin
            if (side) inf2 <= 1'b1;
            else      inf1 <= 1'b1;
          end
          FL_INF1_CLR: begin
            if (side) inf2 <= 1'b0;
            else      inf1 <= 1'b0;
          end
          FL_INF1_FROM2: begin
            if (!side) inf1 <= inf2;
          end
          FL_INF2_FROM1: inf2 <= inf1;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ec_prime_field_point_unit.sv =====
// ----------------------------------------------------------------------------
// ec_prime_field_point_unit
// Affine point arithmetic on y^2 = x^3 + a*x + b over a prime field.
// ----------------------------------------------------------------------------
// One transaction at a time. Raise start with the operands while busy is low;
// the transaction is taken at that edge and busy rises. When the work ends
// result_valid is high for exactly one cycle with the result on result; there
// is no back-pressure, so the receiver must take it in that cycle. busy is
// already low during that cycle, so a new start may be presented there.
// Every product and every operand reduction goes through one bit-serial modular
// multiplier. Rough costs, with W = FIELD_BITS:
//   negate              : about 6 reductions
//   on-curve check      : 6 reductions and up to 4 products
//   point add / double  : one Fermat inverse (up to 2*W products) plus up to 4
//                         further products
//   scalar multiply     : up to 2*SCALAR_BITS point operations
// Configuration: cfg_index 0 = field prime, 1 = curve a, 2 = curve b; other
// indexes are ignored. cfg_ready is always high. Write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ec_prime_field_point_unit_defines.svh"

module ec_prime_field_point_unit import ecpu_pkg::*; #(
  parameter int FIELD_BITS  = 31,
  parameter int SCALAR_BITS = 63
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire ecpu_in_t             operands,
  output logic                      result_valid,
  output ecpu_out_t                 result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [FIELD_W-1:0]   cfg_data
);

  logic                  accept;
  dp_cmd_t               cmd;
  dp_stat_t              stat;
  ctrl_res_t             cres;
  logic [FIELD_BITS-1:0] out_x, out_y;
  logic                  zero_xy;
  logic                  shown_inf, shown_chk, xy_clear;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  ecpu_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .func       (operands.func),
    .first_inf  (operands.first_at_infinity),
    .second_inf (operands.second_at_infinity),
    .stat       (stat),
    .cmd        (cmd),
    .res        (cres),
    .busy       (busy)
  );

  ecpu_dp #(
    .FIELD_BITS  (FIELD_BITS),
    .SCALAR_BITS (SCALAR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operands  (operands),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_x     (out_x),
    .out_y     (out_y)
  );

  // check results carry no point; infinity reads as zero coordinates
  assign zero_xy = cres.inf || cres.is_check;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cres.finish;
    end
    if (cres.finish) begin
      result.result_x           <= zero_xy ? '0 : FIELD_W'(out_x);
      result.result_y           <= zero_xy ? '0 : FIELD_W'(out_y);
      result.result_at_infinity <= cres.inf && !cres.is_check;
      result.on_curve           <= cres.is_check && cres.chk;
    end
  end

  assign shown_inf = result_valid && result.result_at_infinity;
  assign shown_chk = result_valid && result.on_curve;
  assign xy_clear  = (result.result_x == '0) && (result.result_y == '0);

  `ECPU_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted transaction did not raise busy")
  `ECPU_ASSERT_SAME(a_result_idle, result_valid, !busy, "result shown while still busy")
  `ECPU_ASSERT_SAME(a_inf_zero, shown_inf, xy_clear, "infinity result with nonzero coordinates")
  `ECPU_ASSERT_SAME(a_chk_only, shown_chk, !result.result_at_infinity, "on_curve on a point")

endmodule

`default_nettype wire

// ===== bench/ec_prime_field_point_unit_tb.sv =====
// ----------------------------------------------------------------------------
// ec_prime_field_point_unit_tb
// Self-checking bench for the prime-field point unit: directed corner cases,
// then random traffic, mostly curve points, over several field/curve settings,
// checked against an in-bench affine point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ec_prime_field_point_unit_tb;
  import ecpu_pkg::*;

  typedef struct packed {
    bit [63:0] x;
    bit [63:0] y;
    bit        inf;
  } pt_t;

  // Predicts one result per transaction and holds the results still owed.
  class point_scoreboard;
    bit [63:0] prime, coef_a, coef_b;  // registers as written
    bit [63:0] cur_a, cur_b;           // reduced copies used by the math
    ecpu_out_t owed_q[$];
    int        errors;
    int        matched;

    function new();
      prime  = 11;
      coef_a = 1;
      coef_b = 6;
      errors = 0;
      matched = 0;
      refresh();
    endfunction

    function bit [63:0] fred(bit [63:0] v);
      return (prime < 2) ? 64'd0 : v % prime;
    endfunction

    function void refresh();
      cur_a = fred(coef_a);
      cur_b = fred(coef_b);
    endfunction

    function bit [63:0] fadd(bit [63:0] u, bit [63:0] v);
      bit [63:0] s;
      s = u + v;
      if (s >= prime) s = s - prime;
      return s;
    endfunction

    function bit [63:0] fsub(bit [63:0] u, bit [63:0] v);
      return (u >= v) ? u - v : u + prime - v;
    endfunction

    // operands are already reduced, so the product fits in 62 bits
    function bit [63:0] fmul(bit [63:0] u, bit [63:0] v);
      return fred(u * v);
    endfunction

    // Fermat inverse; zero maps to zero
    function bit [63:0] finv(bit [63:0] d);
      bit [63:0] r, e;
      r = fred(1);
      e = (prime >= 2) ? prime - 2 : 0;
      while (e != 0) begin
        if (e[0]) r = fmul(r, d);
        d = fmul(d, d);
        e = e >> 1;
      end
      return r;
    endfunction

    function pt_t padd(pt_t p1, pt_t p2);
      bit [63:0] m, sq, num, x3, y3;
      pt_t r;
      if (p1.inf) return p2;
      if (p2.inf) return p1;
      if (p1.x == p2.x && fadd(p1.y, p2.y) == 0) begin
        r = '0;
        r.inf = 1;
        return r;
      end
      if (p1.x == p2.x && p1.y == p2.y) begin
        sq  = fmul(p1.x, p1.x);
        num = fadd(fadd(fadd(sq, sq), sq), cur_a);
        m   = fmul(num, finv(fadd(p1.y, p1.y)));
      end else begin
        m = fmul(fsub(p2.y, p1.y), finv(fsub(p2.x, p1.x)));
      end
      x3 = fsub(fsub(fmul(m, m), p1.x), p2.x);
      y3 = fsub(fmul(m, fsub(p1.x, x3)), p1.y);
      r.x = x3;
      r.y = y3;
      r.inf = 0;
      return r;
    endfunction

    // right-to-left double-and-add
    function pt_t pscale(bit [63:0] k, pt_t base);
      pt_t acc;
      acc = '0;
      acc.inf = 1;
      while (k != 0) begin
        if (k[0]) acc = padd(acc, base);
        base = padd(base, base);
        k = k >> 1;
      end
      return acc;
    endfunction

    function bit on_curve(pt_t q);
      bit [63:0] lhs, rhs;
      if (q.inf) return 1;
      lhs = fmul(q.y, q.y);
      rhs = fmul(fmul(q.x, q.x), q.x);
      rhs = fadd(rhs, fmul(cur_a, q.x));
      rhs = fadd(rhs, cur_b);
      return lhs == rhs;
    endfunction

    function ecpu_out_t predict(ecpu_in_t v);
      pt_t p1, p2, r;
      ecpu_out_t o;
      refresh();
      p1.x = fred(64'(v.first_x));
      p1.y = fred(64'(v.first_y));
      p1.inf = v.first_at_infinity;
      p2.x = fred(64'(v.second_x));
      p2.y = fred(64'(v.second_y));
      p2.inf = v.second_at_infinity;
      o = '0;
      r = '0;
      case (v.func)
        FN_SCALAR_MUL: r = pscale(64'(v.scalar), p1);
        FN_POINT_ADD:  r = padd(p1, p2);
        FN_NEGATE: begin
          r = p1;
          if (!p1.inf) r.y = fsub(0, p1.y);
        end
        default: o.on_curve = on_curve(p1);
      endcase
      if (r.inf) begin
        r.x = 0;
        r.y = 0;
      end
      o.result_x = r.x[FIELD_W-1:0];
      o.result_y = r.y[FIELD_W-1:0];
      o.result_at_infinity = r.inf;
      return o;
    endfunction

    function void note_transaction(ecpu_in_t v);
      owed_q.push_back(predict(v));
    endfunction

    function void check_result(ecpu_out_t got);
      ecpu_out_t exp;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d inf=%0b on=%0b", $time,
                 got.result_x, got.result_y, got.result_at_infinity, got.on_curve);
        errors++;
        return;
      end
      exp = owed_q.pop_front();
      if (got.result_x !== exp.result_x) begin
        $display("%0t: result_x exp %0d got %0d", $time, exp.result_x, got.result_x);
        errors++;
      end
      if (got.result_y !== exp.result_y) begin
        $display("%0t: result_y exp %0d got %0d", $time, exp.result_y, got.result_y);
        errors++;
      end
      if (got.result_at_infinity !== exp.result_at_infinity) begin
        $display("%0t: result_at_infinity exp %0b got %0b", $time,
                 exp.result_at_infinity, got.result_at_infinity);
        errors++;
      end
      if (got.on_curve !== exp.on_curve) begin
        $display("%0t: on_curve exp %0b got %0b", $time, exp.on_curve, got.on_curve);
        errors++;
      end
      matched++;
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  ecpu_in_t             operands;
  logic                 result_valid;
  ecpu_out_t            result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FIELD_W-1:0]   cfg_data;

  ec_prime_field_point_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operands    (operands),
    .result_valid(result_valid),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  point_scoreboard sb;
  pt_t             base_pt;        // known on-curve point of the current curve
  int              op_count[4];
  int              setting_count;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Results cannot be held off: take every strobe.
  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_result(result);
  end

  // Hard stop: it allows several times the length of the run, even with every
  // scalar at full length.
  initial begin
    #(64'd400_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  // no gap or a short gap about equally often, sometimes a long one
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one transaction; start stays high across back-to-back transactions.
  task automatic issue_op(ecpu_in_t v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    operands <= v;
    do @(posedge clk); while (busy);
    sb.note_transaction(v);
    op_count[v.func]++;
  endtask

  // Let every owed result come back, plus a few idle cycles.
  task automatic drain();
    start <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[FIELD_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_PRIME) sb.prime = 64'(data[FIELD_W-1:0]);
    else if (idx == CFG_A) sb.coef_a = 64'(data[FIELD_W-1:0]);
    else if (idx == CFG_B) sb.coef_b = 64'(data[FIELD_W-1:0]);
    sb.refresh();
  endtask

  // New curve through a chosen point: b is solved from (x0, y0).
  // b_wrap adds multiples of p so b is written unreduced.
  task automatic set_curve(bit [63:0] p, bit [63:0] a, bit [63:0] x0, bit [63:0] y0,
                           bit [63:0] b_wrap);
    bit [63:0] b;
    drain();
    write_reg(CFG_PRIME, p);
    write_reg(CFG_A, a);
    base_pt.x   = sb.fred(x0);
    base_pt.y   = sb.fred(y0);
    base_pt.inf = 0;
    b = sb.fsub(sb.fmul(base_pt.y, base_pt.y),
                sb.fadd(sb.fmul(sb.fmul(base_pt.x, base_pt.x), base_pt.x),
                        sb.fmul(sb.cur_a, base_pt.x)));
    write_reg(CFG_B, b + b_wrap * p);
    setting_count++;
  endtask

  function ecpu_in_t make_op(logic [1:0] fn, bit [63:0] k, pt_t p1, pt_t p2);
    ecpu_in_t v;
    v.func               = fn;
    v.scalar             = k[SCALAR_W-1:0];
    v.first_x            = p1.x[FIELD_W-1:0];
    v.first_y            = p1.y[FIELD_W-1:0];
    v.first_at_infinity  = p1.inf;
    v.second_x           = p2.x[FIELD_W-1:0];
    v.second_y           = p2.y[FIELD_W-1:0];
    v.second_at_infinity = p2.inf;
    return v;
  endfunction

  function pt_t mk_pt(bit [63:0] x, bit [63:0] y, bit inf);
    pt_t q;
    q.x = x;
    q.y = y;
    q.inf = inf;
    return q;
  endfunction

  // random multiple of the base point, so always on the curve
  function pt_t curve_pt();
    return sb.pscale(64'($urandom_range(0, 40)), base_pt);
  endfunction

  function pt_t noise_pt();
    return mk_pt(64'($urandom() & 32'h7fff_ffff), 64'($urandom() & 32'h7fff_ffff),
                 $urandom_range(0, 9) == 0);
  endfunction

  // Scalar multiply cost grows with the bit length of k; keep most short.
  function bit [63:0] pick_scalar();
    if ($urandom_range(0, 39) == 0) return {$urandom(), $urandom()} & 64'h7fff_ffff_ffff_ffff;
    return 64'($urandom_range(0, 15));
  endfunction

  task automatic random_ops(int n);
    pt_t       p1, p2;
    logic [1:0] fn;
    ecpu_in_t  v;
    int        shape;
    repeat (n) begin
      fn = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) < 7) begin
        p1 = curve_pt();
        shape = $urandom_range(0, 5);
        if (shape == 0) p2 = p1;                                    // doubling
        else if (shape == 1) p2 = mk_pt(p1.x, sb.fsub(0, p1.y), p1.inf); // P + -P
        else p2 = curve_pt();
      end else begin
        p1 = noise_pt();
        p2 = noise_pt();
      end
      v = make_op(fn, (fn == FN_SCALAR_MUL) ? pick_scalar()
                      : {$urandom(), $urandom()}, p1, p2);
      issue_op(v);
    end
  endtask

  initial begin
    pt_t inf_pt, pa, pb, pneg;
    sb = new();
    setting_count = 1;
    foreach (op_count[i]) op_count[i] = 0;
    rst       = 1'b1;
    start     = 1'b0;
    operands  = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_PRIME;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on the reset curve y^2 = x^3 + x + 6 mod 11.
    base_pt = mk_pt(2, 4, 0);
    inf_pt  = mk_pt(0, 0, 1);
    pa      = mk_pt(2, 4, 0);
    pb      = mk_pt(3, 5, 0);
    pneg    = mk_pt(2, 7, 0);
    issue_op(make_op(FN_CHECK, 0, pa, inf_pt));
    issue_op(make_op(FN_CHECK, 0, mk_pt(2, 5, 0), inf_pt));           // off curve
    issue_op(make_op(FN_CHECK, 0, inf_pt, inf_pt));                   // infinity counts
    issue_op(make_op(FN_CHECK, 0, mk_pt(2147483646, 2147483646, 0), inf_pt));
    issue_op(make_op(FN_NEGATE, 0, pa, inf_pt));
    issue_op(make_op(FN_NEGATE, 0, inf_pt, inf_pt));
    issue_op(make_op(FN_NEGATE, 0, mk_pt(0, 0, 0), inf_pt));          // y = 0
    issue_op(make_op(FN_NEGATE, 0, mk_pt(2147483646, 2147483646, 0), inf_pt));
    issue_op(make_op(FN_POINT_ADD, 0, pa, pb));
    issue_op(make_op(FN_POINT_ADD, 0, pa, pa));                       // doubling
    issue_op(make_op(FN_POINT_ADD, 0, pa, pneg));                     // to infinity
    issue_op(make_op(FN_POINT_ADD, 0, inf_pt, pb));
    issue_op(make_op(FN_POINT_ADD, 0, pa, inf_pt));
    issue_op(make_op(FN_POINT_ADD, 0, inf_pt, inf_pt));
    issue_op(make_op(FN_POINT_ADD, 0, pa, mk_pt(2, 5, 0)));           // zero divisor
    issue_op(make_op(FN_POINT_ADD, 0, mk_pt(5, 0, 0), mk_pt(5, 0, 0))); // y = 0 double
    issue_op(make_op(FN_POINT_ADD, 0, mk_pt(2147483646, 2147483646, 0),
                     mk_pt(2147483646, 1, 0)));
    issue_op(make_op(FN_SCALAR_MUL, 0, pa, inf_pt));                  // k = 0
    issue_op(make_op(FN_SCALAR_MUL, 1, pa, inf_pt));
    issue_op(make_op(FN_SCALAR_MUL, 13, pa, inf_pt));
    issue_op(make_op(FN_SCALAR_MUL, 5, inf_pt, inf_pt));              // P at infinity
    issue_op(make_op(FN_SCALAR_MUL, 64'h7fff_ffff_ffff_ffff, pa, inf_pt));
    random_ops(15);

    // Largest prime, random a.
    set_curve(64'd2147483647, 64'($urandom() % 32'h7fff_ffff),
              64'($urandom() & 32'h7fff_ffff), 64'($urandom() & 32'h7fff_ffff), 0);
    random_ops(20);

    // Prime 3, a written unreduced as 2^31 - 2.
    set_curve(64'd3, 64'd2147483646, 1, 1, 0);
    random_ops(12);

    // Composite modulus, a = 0, b written unreduced.
    set_curve(64'd15, 64'd0, 2, 3, 1000);
    random_ops(12);

    // Mid-size prime, a = p - 1, b unreduced.
    set_curve(64'd1000003, 64'd1000002, 64'($urandom_range(0, 1000002)),
              64'($urandom_range(0, 1000002)), 7);
    random_ops(20);

    drain();
    $display("Covered %0d field/curve settings: %0d scalar mul, %0d add, %0d negate, %0d check",
             setting_count, op_count[FN_SCALAR_MUL], op_count[FN_POINT_ADD],
             op_count[FN_NEGATE], op_count[FN_CHECK]);
    $display("%0d results compared, %0d mismatches", sb.matched, sb.errors);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ecpu_pkg.sv
rtl/ecpu_dp.sv
rtl/ecpu_ctrl.sv
rtl/ec_prime_field_point_unit.sv
bench/ec_prime_field_point_unit_tb.sv
